// ----- rtl/core/ffsa_pkg.sv -----
// Package for the first-fit segment allocator: table sizes, command, status,
// register and state codes, plus the controller-to-datapath structs. No dependencies.
package ffsa_pkg;

  // table geometry
  localparam int MAX_SEGMENTS = 16;
  localparam int ADDR_BITS    = 10;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int LEN_W        = ADDR_BITS + 1;
  localparam int SUM_W        = LEN_W + 2;
  localparam logic [LEN_W-1:0] ADDR_LIM = {1'b1, {ADDR_BITS{1'b0}}};

  // configuration register indexes and reset values
  localparam logic        REG_POOL_START = 1'b0;
  localparam logic        REG_POOL_END   = 1'b1;
  localparam logic [9:0]  POOL_START_RST = 10'd20;
  localparam logic [10:0] POOL_END_RST   = 11'd100;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADSIZE = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ASCAN,
    S_AREAD,
    S_AUPD,
    S_FSCAN,
    S_FCHK,
    S_FDEC,
    S_FPREV,
    S_WRITE,
    S_LRD,
    S_LWR,
    S_RRD,
    S_RWR,
    S_DONE
  } state_t;

  // Commands issued by the controller to the datapath.
  typedef struct packed {
    logic load;      // capture input item, clear index
    logic init;      // load pool segment
    logic rd_next;   // read table at index + 1
    logic rd_prev;   // read table at index - 1
    logic idx_inc;   // index + 1
    logic idx_dec;   // index - 1
    logic cap_prev;  // keep read data as left neighbor
    logic cap_next;  // keep read data as right neighbor, note insert position
    logic alloc_upd; // write trimmed segment
    logic mv;        // write read data back at index (shift step)
    logic fwrite;    // merge write, or set up an insert
    logic ins_wr;    // write new entry at insert position
    logic set_bad;   // status bad size
    logic set_nofit; // status no fit
    logic set_full;  // status table full
    logic set_done;  // register result
  } dp_cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    cmd_t cmd;
    logic at_end;    // index == used
    logic at_zero;   // index == 0
    logic at_pos;    // index == insert position
    logic fits;      // read entry length covers size
    logic le_base;   // read entry start <= free base
    logic bad;       // size rejected
    logic prev_t;    // left neighbor touches
    logic next_t;    // right neighbor touches
    logic full;      // table full
    logic emptied;   // allocated segment became empty
  } dp_stat_t;

endpackage

// ----- rtl/core/ffsa_ctrl.sv -----
// Controller state machine for the first-fit segment allocator.
// Depends on ffsa_pkg.
module ffsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_fire,
  input  ffsa_pkg::dp_stat_t st,
  output ffsa_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              res_valid
);
  import ffsa_pkg::*;

  state_t state, state_next;
  logic   res_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    res_valid_next = res_valid;
    cmd            = '0;
    if (out_fire) res_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.cmd)
          CMD_INIT: begin
            cmd.init   = 1'b1;
            state_next = S_DONE;
          end
          CMD_ALLOC: begin
            if (st.bad) begin
              cmd.set_bad = 1'b1;
              state_next  = S_DONE;
            end else state_next = S_ASCAN;
          end
          CMD_FREE: begin
            if (st.bad) begin
              cmd.set_bad = 1'b1;
              state_next  = S_DONE;
            end else state_next = S_FSCAN;
          end
          CMD_NOP: state_next = S_DONE;
        endcase
      end
      // alloc: read entry idx, check fit
      S_ASCAN: begin
        if (st.at_end) begin
          cmd.set_nofit = 1'b1;
          state_next    = S_DONE;
        end else state_next = S_AREAD;
      end
      S_AREAD: begin
        if (st.fits) state_next = S_AUPD;
        else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_ASCAN;
        end
      end
      S_AUPD: begin
        cmd.alloc_upd = 1'b1;
        state_next    = st.emptied ? S_LRD : S_DONE;
      end
      // free: find first entry with start > base
      S_FSCAN: begin
        if (st.at_end) begin
          cmd.cap_next = 1'b1; // no right neighbor
          state_next   = S_FDEC;
        end else state_next = S_FCHK;
      end
      S_FCHK: begin
        if (st.le_base) begin
          cmd.idx_inc = 1'b1;
          state_next  = S_FSCAN;
        end else begin
          cmd.cap_next = 1'b1;
          state_next   = S_FDEC;
        end
      end
      // read left neighbor at idx-1 if any
      S_FDEC: begin
        if (st.at_zero) state_next = S_WRITE;
        else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_FPREV;
        end
      end
      S_FPREV: begin
        cmd.cap_prev = 1'b1;
        state_next   = S_WRITE;
      end
      S_WRITE: begin
        if (st.prev_t && st.next_t) begin
          cmd.fwrite = 1'b1;
          state_next = S_LRD;
        end else if (st.prev_t || st.next_t) begin
          cmd.fwrite = 1'b1;
          state_next = S_DONE;
        end else if (st.full) begin
          cmd.set_full = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.fwrite = 1'b1;
          state_next = S_RRD;
        end
      end
      // removal: copy entry idx+1 down to idx until idx reaches used
      S_LRD: begin
        if (st.at_end) state_next = S_DONE;
        else begin
          cmd.rd_next = 1'b1;
          state_next  = S_LWR;
        end
      end
      S_LWR: begin
        cmd.mv      = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_LRD;
      end
      // insert: copy entry idx-1 up to idx down to the insert position
      S_RRD: begin
        if (st.at_pos) begin
          cmd.ins_wr = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_RWR;
        end
      end
      S_RWR: begin
        cmd.mv      = 1'b1;
        cmd.idx_dec = 1'b1;
        state_next  = S_RRD;
      end
      S_DONE: begin
        if (!res_valid || out_fire) begin
          cmd.set_done   = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/core/ffsa_dp.sv -----
// Datapath for the first-fit segment allocator: segment table memory,
// index, item registers and result register. Depends on ffsa_pkg.
module ffsa_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  ffsa_pkg::dp_cmd_t     cmd,
  output ffsa_pkg::dp_stat_t    st,
  input  logic [1:0]            in_cmd,
  input  logic [10:0]           in_size,
  input  logic [9:0]            in_base,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [10:0]           cfg_data,
  output logic [1:0]            res_status,
  output logic [9:0]            res_base,
  output logic [4:0]            res_count
);
  import ffsa_pkg::*;

  // configuration
  logic [9:0]  pool_start;
  logic [10:0] pool_end;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_start <= POOL_START_RST;
      pool_end   <= POOL_END_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_POOL_END) pool_end <= cfg_data;
      else                           pool_start <= cfg_data[9:0];
    end
  end

  // pool size clipped to the address space
  logic [LEN_W-1:0] ps_s, ps_e, psize;
  always_comb begin
    ps_s  = LEN_W'(pool_start) & (ADDR_LIM - LEN_W'(1));
    ps_e  = (pool_end < ADDR_LIM) ? pool_end : ADDR_LIM;
    psize = (ps_e > ps_s) ? ps_e - ps_s : '0;
  end

  // table memory
  logic [ADDR_BITS-1:0] mem_s [MAX_SEGMENTS];
  logic [LEN_W-1:0]     mem_l [MAX_SEGMENTS];
  logic [ADDR_BITS-1:0] rd_s;
  logic [LEN_W-1:0]     rd_l;
  logic                 we;
  logic [IDX_W-1:0]     wa, ra;
  logic [ADDR_BITS-1:0] wd_s;
  logic [LEN_W-1:0]     wd_l;

  // item and control registers
  cmd_t                 icmd;
  logic [LEN_W-1:0]     isize;
  logic [ADDR_BITS-1:0] ibase;
  logic [CNT_W-1:0]     used, idx, pos;
  logic [CNT_W-1:0]     idx_p1, idx_m1, pos_m1;
  logic [ADDR_BITS-1:0] p_s, n_s;
  logic [LEN_W-1:0]     p_l, n_l;
  logic                 p_v, n_v;
  status_t              status;
  logic [ADDR_BITS-1:0] abase;

  assign idx_p1 = idx + 1'b1;
  assign idx_m1 = idx - 1'b1;
  assign pos_m1 = pos - 1'b1;

  // read path: one registered read port
  always_comb begin
    ra = idx[IDX_W-1:0];
    if (cmd.rd_next)      ra = idx_p1[IDX_W-1:0];
    else if (cmd.rd_prev) ra = idx_m1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    rd_s <= mem_s[ra];
    rd_l <= mem_l[ra];
    if (we) begin
      mem_s[wa] <= wd_s;
      mem_l[wa] <= wd_l;
    end
  end

  // sums and merge caps
  logic [SUM_W-1:0] fend, pend, room_p, room_b, sum3, sum2, sumn;
  logic [SUM_W-1:0] cap3, cap2, capn;
  logic [LEN_W-1:0] alen;
  always_comb begin
    fend   = SUM_W'(ibase) + SUM_W'(isize);
    pend   = SUM_W'(p_s) + SUM_W'(p_l);
    room_p = SUM_W'(ADDR_LIM) - SUM_W'(p_s);
    room_b = SUM_W'(ADDR_LIM) - SUM_W'(ibase);
    sum2   = SUM_W'(p_l) + SUM_W'(isize);
    sum3   = sum2 + SUM_W'(n_l);
    sumn   = SUM_W'(n_l) + SUM_W'(isize);
    cap3   = (sum3 < room_p) ? sum3 : room_p;
    cap2   = (sum2 < room_p) ? sum2 : room_p;
    capn   = (sumn < room_b) ? sumn : room_b;
    alen   = rd_l - isize;
  end

  logic prev_t, next_t;
  assign prev_t = p_v && (pend == SUM_W'(ibase));
  assign next_t = n_v && (fend == SUM_W'(n_s));

  // write port selection
  always_comb begin
    we   = 1'b0;
    wa   = idx[IDX_W-1:0];
    wd_s = rd_s;
    wd_l = rd_l;
    if (cmd.init) begin
      we   = 1'b1;
      wa   = '0;
      wd_s = ps_s[ADDR_BITS-1:0];
      wd_l = psize;
    end else if (cmd.alloc_upd) begin
      we   = 1'b1;
      wd_s = rd_s + isize[ADDR_BITS-1:0];
      wd_l = alen;
    end else if (cmd.mv) begin
      we = 1'b1;
    end else if (cmd.ins_wr) begin
      we   = 1'b1;
      wa   = pos[IDX_W-1:0];
      wd_s = ibase;
      wd_l = isize;
    end else if (cmd.fwrite && prev_t) begin
      we   = 1'b1;
      wa   = pos_m1[IDX_W-1:0];
      wd_s = p_s;
      wd_l = next_t ? cap3[LEN_W-1:0] : cap2[LEN_W-1:0];
    end else if (cmd.fwrite && next_t) begin
      we   = 1'b1;
      wa   = pos[IDX_W-1:0];
      wd_s = ibase;
      wd_l = capn[LEN_W-1:0];
    end
  end

  // item, index, neighbor and status registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      icmd   <= cmd_t'(in_cmd);
      isize  <= in_size;
      ibase  <= in_base;
      idx    <= '0;
      pos    <= '0;
      abase  <= '0;
      p_v    <= 1'b0;
      n_v    <= 1'b0;
      status <= ST_OK;
    end else begin
      if (cmd.idx_inc)      idx <= idx_p1;
      else if (cmd.idx_dec) idx <= idx_m1;
      else if (cmd.fwrite && prev_t && next_t) idx <= pos;
      else if (cmd.fwrite && !prev_t && !next_t) idx <= used;
      if (cmd.cap_next) begin
        pos <= idx;
        n_v <= (idx != used);
        n_s <= rd_s;
        n_l <= rd_l;
      end
      if (cmd.cap_prev) begin
        p_v <= 1'b1;
        p_s <= rd_s;
        p_l <= rd_l;
      end
      if (cmd.alloc_upd) abase <= rd_s;
      if (cmd.set_bad)        status <= ST_BADSIZE;
      else if (cmd.set_nofit) status <= ST_NOFIT;
      else if (cmd.set_full)  status <= ST_FULL;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) used <= '0;
    else if (cmd.init) used <= (psize != '0) ? CNT_W'(1) : '0;
    else if (cmd.alloc_upd && alen == '0) used <= used - 1'b1;
    else if (cmd.fwrite && prev_t && next_t) used <= used - 1'b1;
    else if (cmd.ins_wr) used <= used + 1'b1;
  end

  // status to controller
  always_comb begin
    st.cmd     = icmd;
    st.at_end  = (idx == used);
    st.at_zero = (idx == '0);
    st.at_pos  = (idx == pos);
    st.fits    = (rd_l >= isize);
    st.le_base = (rd_s <= ibase);
    st.bad     = (icmd == CMD_ALLOC) ? (isize == '0 || isize > psize)
                                     : (isize == '0 || fend > SUM_W'(ADDR_LIM));
    st.prev_t  = prev_t;
    st.next_t  = next_t;
    st.full    = (used == CNT_W'(MAX_SEGMENTS));
    st.emptied = (alen == '0);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_status <= ST_OK;
      res_base   <= '0;
      res_count  <= '0;
    end else if (cmd.set_done) begin
      res_status <= status;
      res_base   <= abase;
      res_count  <= used;
    end
  end
endmodule

// ----- rtl/core/first_fit_segment_allocator_top.sv -----
// First-fit segment allocator with coalescing, one command per transfer.
// Time from input transfer to result valid is set by the table scan and by
// the entry shifts through one read port; init, no-op and a rejected size
// skip both. The next transfer can be taken once the result is registered.
// Reset (rst, synchronous) empties the table and loads pool_start=20, pool_end=100.
module first_fit_segment_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // cmd[1:0], req_size[12:2], free_base[22:13]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status[1:0], alloc_base[11:2], segment_count[16:12]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import ffsa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;
  logic     busy, in_fire, out_fire;
  logic [1:0]  r_status;
  logic [9:0]  r_base;
  logic [4:0]  r_count;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {7'd0, r_count, r_base, r_status};

  ffsa_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .st, .cmd, .busy,
    .res_valid(m_axis_tvalid)
  );

  ffsa_dp u_dp (
    .clk, .rst, .cmd, .st,
    .in_cmd(s_axis_tdata[1:0]), .in_size(s_axis_tdata[12:2]),
    .in_base(s_axis_tdata[22:13]),
    .cfg_we, .cfg_index, .cfg_data,
    .res_status(r_status), .res_base(r_base), .res_count(r_count)
  );

  // segment count never exceeds table depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (r_count <= 5'(MAX_SEGMENTS))) else $error("count overflow");
  // no item accepted while a command is in work
  a_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_fire) else $error("accept while busy");
  // a failed command reports base zero
  a_base: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && r_status != ST_OK) |-> (r_base == 10'd0)) else $error("bad base");
endmodule
